/* hdl/multi_cpu_ready_queue_scheduler_core_macros.svh */
// Assertion macros used by the scheduler datapath.
`ifndef MULTI_CPU_READY_QUEUE_SCHEDULER_CORE_MACROS_SVH
`define MULTI_CPU_READY_QUEUE_SCHEDULER_CORE_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define MCRQS_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("scheduler assertion failed");

// Checks that a consequence holds in the cycle after its antecedent.
`define MCRQS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

/* hdl/mcrqs_pkg.sv */
// Shared types and codes of the ready-queue scheduler.
package mcrqs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_REINS,
    ST_EMIT
  } state_t;

  localparam logic [2:0] OP_WAKE    = 3'd0;
  localparam logic [2:0] OP_PREEMPT = 3'd1;
  localparam logic [2:0] OP_YIELD   = 3'd2;
  localparam logic [2:0] OP_TERM    = 3'd3;
  localparam logic [2:0] OP_IDLE    = 3'd4;

  localparam logic [1:0] RK_SWITCH = 2'd0;
  localparam logic [1:0] RK_FORCE  = 2'd1;
  localparam logic [1:0] RK_DROP   = 2'd2;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_SLICE = 2'd1;
  localparam logic [1:0] CFG_CPUS  = 2'd2;

  localparam logic [1:0] MODE_PRIO = 2'd2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    RS_KEEP,
    RS_DISPATCH,
    RS_FORCE,
    RS_DROP
  } res_src_t;

  typedef struct packed {
    logic     accept;
    logic     rd_scan;
    logic     q_insert;
    logic     dispatch;
    logic     save_running;
    logic     scan_start;
    logic     scan_step;
    logic     res_load;
    res_src_t res_src;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       mode_prio;
    logic       cpus_nz;
    logic       cpu_ok;
    logic       busy;
    logic       keep;
    logic       scan_idle;
    logic       scan_last;
    logic       scan_hit;
    logic       out_free;
  } stat_t;

endpackage

/* hdl/mcrqs_dpath.sv */
// Datapath: configuration, ready queue, CPU table, scan unit and result registers.
`include "multi_cpu_ready_queue_scheduler_core_macros.svh"
module mcrqs_dpath
  import mcrqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int MAX_CPUS    = 16,
  parameter int ID_BITS     = 8,
  parameter int PRIO_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_cpu,
  input  logic [7:0]  in_pid,
  input  logic [7:0]  in_prio,
  input  logic        m_ready,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_target,
  output logic        out_dvalid,
  output logic [7:0]  out_proc,
  output logic [15:0] out_slice
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IW    = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int NC_W  = $clog2(MAX_CPUS + 1);

  logic [1:0]  mode;
  logic [15:0] slice;
  logic [4:0]  cpus;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 2'd0;
      slice <= 16'd0;
      cpus  <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode  <= cfg_data[1:0];
        CFG_SLICE: slice <= cfg_data;
        CFG_CPUS:  cpus  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [NC_W-1:0] ncpu_cfg;
  assign ncpu_cfg = (32'(cpus) > 32'(MAX_CPUS)) ? NC_W'(MAX_CPUS) : NC_W'(cpus);

  // Item registers; a preempted process overwrites the id and priority.
  logic [2:0]           op_q;
  logic [3:0]           cpu_q;
  logic [ID_BITS-1:0]   pid_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [NC_W-1:0]      ncpu_q;

  logic [ID_BITS-1:0]   q_id [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] q_pr [QUEUE_DEPTH];
  logic [CNT_W-1:0]     cnt;

  logic                 cpu_busy [MAX_CPUS];
  logic [ID_BITS-1:0]   cpu_proc [MAX_CPUS];
  logic [PRIO_BITS-1:0] cpu_prio [MAX_CPUS];

  logic [IW-1:0]        cpu_idx, rd_addr, scan_idx, best_idx;
  logic [PRIO_BITS-1:0] best_pr;
  logic [ID_BITS-1:0]   proc_rd;
  logic [PRIO_BITS-1:0] prio_rd;
  logic                 busy_rd;

  assign cpu_idx = IW'(cpu_q);
  assign rd_addr = cmd.rd_scan ? scan_idx : cpu_idx;
  assign proc_rd = cpu_proc[rd_addr];
  assign prio_rd = cpu_prio[rd_addr];
  assign busy_rd = cpu_busy[rd_addr];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= in_op;
      cpu_q  <= in_cpu;
      pid_q  <= ID_BITS'(in_pid);
      prio_q <= PRIO_BITS'(in_prio);
      ncpu_q <= ncpu_cfg;
    end else if (cmd.save_running) begin
      pid_q  <= proc_rd;
      prio_q <= prio_rd;
    end
  end

  // Insert slot: the first entry that is free or, in priority mode, less urgent.
  logic [QUEUE_DEPTH-1:0] hit, after, prev_after;
  logic [ID_BITS-1:0]     dn_id [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0]   dn_pr [QUEUE_DEPTH];
  logic [ID_BITS-1:0]     up_id [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0]   up_pr [QUEUE_DEPTH];
  logic                   mode_prio, empty, do_pop;

  assign mode_prio = (mode == MODE_PRIO);
  assign empty     = (cnt == '0);
  assign do_pop    = cmd.dispatch && !empty;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit[i] = (CNT_W'(i) >= cnt) || (mode_prio && (q_pr[i] > prio_q));
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      after[i] = |(hit & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
    end
  end

  assign prev_after = {after[QUEUE_DEPTH-2:0], 1'b0};

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_nb
    if (g == 0) begin : g_first
      assign dn_id[g] = pid_q;
      assign dn_pr[g] = prio_q;
    end else begin : g_rest
      assign dn_id[g] = q_id[g-1];
      assign dn_pr[g] = q_pr[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign up_id[g] = q_id[g];
      assign up_pr[g] = q_pr[g];
    end else begin : g_mid
      assign up_id[g] = q_id[g+1];
      assign up_pr[g] = q_pr[g+1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.q_insert && after[i]) begin
        q_id[i] <= prev_after[i] ? dn_id[i] : pid_q;
        q_pr[i] <= prev_after[i] ? dn_pr[i] : prio_q;
      end else if (do_pop) begin
        q_id[i] <= up_id[i];
        q_pr[i] <= up_pr[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.q_insert) begin
      cnt <= cnt + 1'b1;
    end else if (do_pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CPUS; i++) cpu_busy[i] <= 1'b0;
    end else if (cmd.dispatch) begin
      cpu_busy[cpu_idx] <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      cpu_proc[cpu_idx] <= q_id[0];
      cpu_prio[cpu_idx] <= q_pr[0];
    end
  end

  // Scan for the least urgent running CPU, one CPU a cycle.
  logic                 cand_better;
  logic [PRIO_BITS-1:0] cand_pr;
  logic [IW-1:0]        cand_idx;

  assign cand_better = prio_rd > best_pr;
  assign cand_pr     = cand_better ? prio_rd : best_pr;
  assign cand_idx    = cand_better ? scan_idx : best_idx;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      best_idx <= '0;
      best_pr  <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      best_idx <= cand_idx;
      best_pr  <= cand_pr;
    end
  end

  always_comb begin
    st.op        = op_q;
    st.full      = (cnt == CNT_W'(QUEUE_DEPTH));
    st.empty     = empty;
    st.mode_prio = mode_prio;
    st.cpus_nz   = (ncpu_q != '0);
    st.cpu_ok    = (32'(cpu_q) < 32'(ncpu_q));
    st.busy      = busy_rd;
    st.keep      = empty || (mode_prio && (q_pr[0] > prio_rd));
    st.scan_idle = !busy_rd;
    st.scan_last = ((32'(scan_idx) + 32'd1) == 32'(ncpu_q));
    st.scan_hit  = cand_pr > prio_q;
    st.out_free  = !out_valid || m_ready;
  end

  // Pending result, then the output register that holds a beat until taken.
  logic [1:0]  r_kind;
  logic [3:0]  r_target;
  logic        r_dvalid;
  logic [7:0]  r_proc;
  logic [15:0] r_slice;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_src)
        RS_KEEP: begin
          r_kind <= RK_SWITCH; r_target <= cpu_q; r_dvalid <= 1'b1;
          r_proc <= 8'(proc_rd); r_slice <= slice;
        end
        RS_DISPATCH: begin
          r_kind <= RK_SWITCH; r_target <= cpu_q; r_dvalid <= !empty;
          r_proc <= empty ? 8'd0 : 8'(q_id[0]); r_slice <= slice;
        end
        RS_FORCE: begin
          r_kind <= RK_FORCE; r_target <= 4'(cand_idx); r_dvalid <= 1'b0;
          r_proc <= 8'd0; r_slice <= 16'd0;
        end
        default: begin
          r_kind <= RK_DROP; r_target <= 4'd0; r_dvalid <= 1'b0;
          r_proc <= 8'd0; r_slice <= 16'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind   <= r_kind;
      out_target <= r_target;
      out_dvalid <= r_dvalid;
      out_proc   <= r_proc;
      out_slice  <= r_slice;
    end
  end

  `MCRQS_ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(QUEUE_DEPTH))
  `MCRQS_ASSERT_NEXT(a_insert_grows, cmd.q_insert, cnt == $past(cnt) + 1'b1)
  `MCRQS_ASSERT_NEXT(a_pop_shrinks, cmd.dispatch && !st.empty, cnt == $past(cnt) - 1'b1)
  `MCRQS_ASSERT_ALWAYS(a_only_switch_dispatches, !out_valid || out_kind == RK_SWITCH || !out_dvalid)

endmodule

/* hdl/mcrqs_ctrl.sv */
// Controller: sequences each event through the datapath.
module mcrqs_ctrl
  import mcrqs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  input  logic  in_valid,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (st.op == OP_WAKE) begin
          if (st.full) state_next = ST_EMIT;
          else if (st.mode_prio && st.cpus_nz) state_next = ST_SCAN;
          else state_next = ST_IDLE;
        end else if (!st.cpu_ok) begin
          state_next = ST_IDLE;
        end else begin
          case (st.op) inside
            OP_PREEMPT: begin
              if (st.busy && !st.keep) state_next = ST_REINS;
              else state_next = ST_EMIT;
            end
            OP_YIELD, OP_TERM: state_next = ST_EMIT;
            OP_IDLE: state_next = (st.busy || st.empty) ? ST_IDLE : ST_EMIT;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (st.scan_idle) state_next = ST_IDLE;
        else if (st.scan_last) state_next = st.scan_hit ? ST_EMIT : ST_IDLE;
      end
      ST_REINS: state_next = ST_EMIT;
      ST_EMIT: if (st.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_src  = RS_DISPATCH;
    in_ready     = (state == ST_IDLE);
    cmd.accept   = (state == ST_IDLE) && in_valid;
    cmd.rd_scan  = (state == ST_SCAN);
    unique case (state)
      ST_EXEC: begin
        if (st.op == OP_WAKE) begin
          if (st.full) begin
            cmd.res_load = 1'b1;
            cmd.res_src  = RS_DROP;
          end else begin
            cmd.q_insert   = 1'b1;
            cmd.scan_start = 1'b1;
          end
        end else if (st.cpu_ok) begin
          case (st.op) inside
            OP_PREEMPT: begin
              cmd.res_load = 1'b1;
              if (st.busy && st.keep) begin
                cmd.res_src = RS_KEEP;
              end else begin
                cmd.dispatch     = 1'b1;
                cmd.save_running = st.busy;
              end
            end
            OP_YIELD, OP_TERM: begin
              cmd.dispatch = 1'b1;
              cmd.res_load = 1'b1;
            end
            OP_IDLE: begin
              cmd.dispatch = !(st.busy || st.empty);
              cmd.res_load = !(st.busy || st.empty);
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (!st.scan_idle) begin
          if (st.scan_last) begin
            cmd.res_load = st.scan_hit;
            cmd.res_src  = RS_FORCE;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      ST_REINS: cmd.q_insert = 1'b1;
      ST_EMIT:  cmd.emit = st.out_free;
      default: ;
    endcase
  end

endmodule

/* hdl/multi_cpu_ready_queue_scheduler_core.sv */
// Top level of the multi-CPU ready-queue scheduler.
//
//  Channel   Handshake          Payload
//  s_*       s_tvalid/s_tready  s_tuser opcode, s_tdata cpu, process id, priority
//  m_*       m_tvalid/m_tready  m_tuser result kind, m_tdata target and dispatch
//  cfg_*     cfg_valid/ready    cfg_index register, cfg_data value
//
// An event that gives no result goes from the execute state back to idle; a dispatch
// or a dropped wake-up passes through the emit state, and a preempt whose running
// process goes back into the queue passes the reinsert state first; a priority-mode
// wake-up scans the CPU table one CPU a cycle and ends early at the first idle CPU.
// A new beat is accepted only once the controller is back in its idle state.
// The output register holds a beat until it is taken; a further result waits.
// Reset is synchronous; it empties the queue and marks every CPU idle.
module multi_cpu_ready_queue_scheduler_core
  import mcrqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int MAX_CPUS    = 16,
  parameter int ID_BITS     = 8,
  parameter int PRIO_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // cpu_id, process_id, process_priority
  input  logic [2:0]             s_tuser,  // opcode
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // target_cpu, dispatch_valid,
                                           // dispatch_process, dispatch_slice
  output logic [1:0]             m_tuser,  // result_kind
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  cmd_t  cmd;
  stat_t st;

  logic [3:0]  out_target;
  logic        out_dvalid;
  logic [7:0]  out_proc;
  logic [15:0] out_slice;

  assign cfg_ready = 1'b1;

  mcrqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  mcrqs_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_CPUS    (MAX_CPUS),
    .ID_BITS     (ID_BITS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (s_tuser),
    .in_cpu     (s_tdata[3:0]),
    .in_pid     (s_tdata[11:4]),
    .in_prio    (s_tdata[19:12]),
    .m_ready    (m_tready),
    .out_valid  (m_tvalid),
    .out_kind   (m_tuser),
    .out_target (out_target),
    .out_dvalid (out_dvalid),
    .out_proc   (out_proc),
    .out_slice  (out_slice)
  );

  assign m_tdata = {3'd0, out_slice, out_proc, out_dvalid, out_target};

endmodule
